@@ rtl/core/lari_pkg.sv @@
// Package for the lens angle/radius lookup and interpolation block.
// Holds widths, operation and register codes, controller types and helpers.
// No dependencies.
package lari_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PT_W        = IDX_W + 1;
  localparam int VALUE_W     = 24;
  localparam int STEP_W      = 24;
  localparam int SIZE_W      = 11;
  localparam int CFG_IDX_W   = 4;
  localparam int END_W       = STEP_W + PT_W;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int DIV_CNT_W   = $clog2(ACC_W);

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1830);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_TO_RADIUS = 2'd1,
    OP_TO_ANGLE  = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LATCH, CMD_END_MUL, CMD_END_SET,
    CMD_RES_ZERO, CMD_RES_LAST, CMD_RES_END,
    CMD_DIV_K, CMD_K_SET, CMD_K_MUL, CMD_FRAC, CMD_MUL_B, CMD_MUL_U, CMD_ACC,
    CMD_DIV_I, CMD_RES_Q,
    CMD_SRCH_INIT, CMD_SRCH_RD, CMD_SRCH_CMP, CMD_BASE_RD, CMD_PB, CMD_PU,
    CMD_RES_BASE, CMD_D_MUL, CMD_DIV_D, CMD_RES_ADD, CMD_PUSH
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_END_MUL, S_END_SET, S_DECIDE,
    S_K_DIV, S_K_WAIT, S_K_SET, S_K_MUL, S_FRAC, S_MUL_B, S_MUL_U, S_ACC,
    S_I_DIV, S_I_WAIT, S_I_RES,
    S_SRCH_INIT, S_SRCH, S_SRCH_CMP, S_PB, S_PU, S_DEG,
    S_D_DIV, S_D_WAIT, S_D_RES, S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic ge_end;
    logic gt_last;
    logic more;
    logic degen;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [VALUE_W-1:0] sat_value(input logic [END_W-1:0] x);
    logic [VALUE_W-1:0] r;
    r = (|x[END_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : x[VALUE_W-1:0];
    return r;
  endfunction

endpackage

@@ rtl/core/lari_ifs.sv @@
// Channel interfaces: query request, result, and register write.
// Depends on nothing; widths match lari_pkg.
interface lari_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [9:0]  entry_index;
  logic [23:0] operand;
  modport source (output valid, operation, entry_index, operand, input ready);
  modport sink   (input valid, operation, entry_index, operand, output ready);
endinterface

interface lari_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] result_value;
  logic        status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

interface lari_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/lens_angle_radius_lut_interp.sv @@
// Top level of the lens angle/radius lookup with linear interpolation.
// Depends on lari_pkg, lari_ifs, lari_ctrl, lari_dpath (lari_div).
//
//  channel  dir  payload                                  request taken when
//  req      in   operation, entry_index, operand          req.valid & req.ready
//  rsp      out  result_value, status                     rsp.valid & rsp.ready
//  cfg      in   index (0 angle_step, 1 table_size), data cfg.valid (ready tied high)
//
// One request at a time. Load, unused code and clamped queries skip the arithmetic. Angle to
// radius takes two passes of the bit-serial divider. Radius to angle runs a binary search
// (at most 10 steps) over the one table read port, then at most one divider pass.
// Synchronous reset restores the configuration registers and control state; table
// contents are kept. A result waiting in the output register does not block the next
// request; that request then waits in its done state until the register frees.
module lens_angle_radius_lut_interp (
  input logic clk,
  input logic rst,
  lari_req_if.sink   req,
  lari_rsp_if.source rsp,
  lari_cfg_if.sink   cfg
);
  import lari_pkg::*;

  cmd_t       cmd;
  dp_status_t stat;

  assign cfg.ready = 1'b1;

  lari_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lari_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_idx      (cfg.index),
    .cfg_data     (cfg.data),
    .operation    (req.operation),
    .entry_index  (req.entry_index),
    .operand      (req.operand),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .status       (rsp.status)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  a_latch_on_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_LATCH) |-> (req.valid && req.ready))
    else $error("latch without accepted request");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_PUSH) |=> rsp.valid)
    else $error("result push lost");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_PUSH) |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten");

endmodule

@@ rtl/core/lari_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on lari_pkg.
module lari_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lari_pkg::ACC_W-1:0]   dividend,
  input  logic [lari_pkg::VALUE_W-1:0] divisor,
  output logic                         done,
  output logic [lari_pkg::VALUE_W-1:0] quotient
);
  import lari_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [VALUE_W-1:0]   rem;
  logic [VALUE_W-1:0]   dsr;
  logic [ACC_W-1:0]     dvd;
  logic [VALUE_W:0]     trial;
  logic                 fits;
  logic [VALUE_W:0]     diff;

  assign trial = {rem, dvd[ACC_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(ACC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem      <= fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
      dvd      <= {dvd[ACC_W-2:0], 1'b0};
      quotient <= {quotient[VALUE_W-2:0], fits};
    end
  end

endmodule

@@ rtl/core/lari_dpath.sv @@
// Datapath: radius table, registers, shared multiplier, divider, result register.
// Depends on lari_pkg and lari_div.
module lari_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  lari_pkg::cmd_t                 cmd,
  output lari_pkg::dp_status_t           stat,
  input  logic                           cfg_we,
  input  logic [lari_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [lari_pkg::STEP_W-1:0]    cfg_data,
  input  logic [1:0]                     operation,
  input  logic [lari_pkg::IDX_W-1:0]     entry_index,
  input  logic [lari_pkg::VALUE_W-1:0]   operand,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lari_pkg::VALUE_W-1:0]   result_value,
  output logic                           status
);
  import lari_pkg::*;

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] memq;
  logic               pz;

  logic [STEP_W-1:0]  step_cfg;
  logic [SIZE_W-1:0]  size_cfg;
  logic [STEP_W-1:0]  eff_step;
  logic [PT_W-1:0]    eff_n;

  op_t                op_r;
  logic [VALUE_W-1:0] val_r, step_r, last_r, frac_r, rb_r, ru_r, pb_r, pu_r, res_r;
  logic [PT_W-1:0]    n_r;
  logic [END_W-1:0]   end_r, base_r;
  logic [IDX_W-1:0]   k_r, lo_r, hi_r, mid_r;
  logic [ACC_W-1:0]   acc_r;
  logic               st_r;

  logic [VALUE_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  prod;
  logic               rd_en;
  logic [PT_W-1:0]    rd_pt;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] ptval;
  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_c;
  logic [VALUE_W-1:0] span, dif, d_c;

  logic               div_start, div_done;
  logic [ACC_W-1:0]   div_dvd;
  logic [VALUE_W-1:0] div_dsr, div_q;

  lari_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign eff_step = (step_cfg == '0) ? STEP_W'(1) : step_cfg;
  always_comb begin
    if (size_cfg > SIZE_W'(TABLE_DEPTH)) eff_n = PT_W'(TABLE_DEPTH);
    else if (size_cfg < SIZE_W'(2))      eff_n = PT_W'(2);
    else                                 eff_n = PT_W'(size_cfg);
  end

  assign ptval   = pz ? '0 : memq;
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r} + (IDX_W+1)'(1);
  assign mid_c   = mid_sum[IDX_W:1];
  assign span    = pu_r - pb_r;
  assign dif     = val_r - pb_r;
  assign d_c     = (dif > span) ? span : dif;
  assign rd_addr = IDX_W'(rd_pt - PT_W'(1));

  always_comb begin
    mul_a     = '0;
    mul_b     = step_r;
    rd_en     = 1'b0;
    rd_pt     = '0;
    div_start = 1'b0;
    div_dvd   = ACC_W'(val_r);
    div_dsr   = step_r;
    case (cmd)
      CMD_END_MUL: begin
        mul_a = VALUE_W'(n_r);
        rd_en = 1'b1;
        rd_pt = n_r;
      end
      CMD_K_MUL: begin
        mul_a = VALUE_W'(k_r);
        rd_en = 1'b1;
        rd_pt = PT_W'(k_r);
      end
      CMD_FRAC: begin
        rd_en = 1'b1;
        rd_pt = PT_W'(k_r) + PT_W'(1);
      end
      CMD_MUL_B: begin
        mul_a = rb_r;
        mul_b = step_r - frac_r;
      end
      CMD_MUL_U: begin
        mul_a = ru_r;
        mul_b = frac_r;
      end
      CMD_SRCH_RD: begin
        rd_en = 1'b1;
        rd_pt = PT_W'(mid_c);
      end
      CMD_BASE_RD: begin
        mul_a = VALUE_W'(lo_r);
        rd_en = 1'b1;
        rd_pt = PT_W'(lo_r);
      end
      CMD_PB: begin
        rd_en = 1'b1;
        rd_pt = PT_W'(lo_r) + PT_W'(1);
      end
      CMD_D_MUL: mul_a = d_c;
      CMD_DIV_K: div_start = 1'b1;
      CMD_DIV_I: begin
        div_start = 1'b1;
        div_dvd   = acc_r;
      end
      CMD_DIV_D: begin
        div_start = 1'b1;
        div_dvd   = ACC_W'(prod);
        div_dsr   = span;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd == CMD_LATCH && op_t'(operation) == OP_LOAD) begin
      mem[entry_index] <= operand;
    end
    if (rd_en) begin
      memq <= mem[rd_addr];
      pz   <= (rd_pt == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        op_r   <= op_t'(operation);
        val_r  <= operand;
        step_r <= eff_step;
        n_r    <= eff_n;
      end
      CMD_END_SET: begin
        end_r  <= prod[END_W-1:0];
        last_r <= ptval;
      end
      CMD_RES_ZERO: begin
        res_r <= '0;
        st_r  <= 1'b0;
      end
      CMD_RES_LAST: begin
        res_r <= last_r;
        st_r  <= END_W'(val_r) > end_r;
      end
      CMD_RES_END: begin
        res_r <= sat_value(end_r);
        st_r  <= 1'b1;
      end
      CMD_K_SET: k_r <= div_q[IDX_W-1:0];
      CMD_FRAC: begin
        frac_r <= val_r - prod[VALUE_W-1:0];
        rb_r   <= ptval;
      end
      CMD_MUL_B: ru_r <= ptval;
      CMD_MUL_U: acc_r <= ACC_W'(prod);
      CMD_ACC:   acc_r <= acc_r + ACC_W'(prod);
      CMD_RES_Q: begin
        res_r <= div_q;
        st_r  <= 1'b0;
      end
      CMD_SRCH_INIT: begin
        lo_r <= '0;
        hi_r <= IDX_W'(n_r - PT_W'(1));
      end
      CMD_SRCH_RD: mid_r <= mid_c;
      CMD_SRCH_CMP: begin
        if (ptval <= val_r) lo_r <= mid_r;
        else                hi_r <= mid_r - IDX_W'(1);
      end
      CMD_PB: begin
        pb_r   <= ptval;
        base_r <= END_W'(prod);
      end
      CMD_PU: pu_r <= ptval;
      CMD_RES_BASE: begin
        res_r <= sat_value(base_r);
        st_r  <= 1'b0;
      end
      CMD_RES_ADD: begin
        res_r <= sat_value(base_r + END_W'(div_q));
        st_r  <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cfg  <= STEP_RESET;
      size_cfg  <= SIZE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ANGLE_STEP: step_cfg <= cfg_data;
          CFG_TABLE_SIZE: size_cfg <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (cmd == CMD_PUSH)  out_valid <= 1'b1;
      else if (out_ready)   out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_PUSH) begin
      result_value <= res_r;
      status       <= st_r;
    end
  end

  assign stat.op       = op_r;
  assign stat.ge_end   = END_W'(val_r) >= end_r;
  assign stat.gt_last  = val_r > last_r;
  assign stat.more     = lo_r < hi_r;
  assign stat.degen    = (pu_r <= pb_r) || (val_r < pb_r);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

@@ rtl/core/lari_ctrl.sv @@
// Controller: sequences load, angle-to-radius and radius-to-angle requests.
// Depends on lari_pkg.
module lari_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  lari_pkg::dp_status_t stat,
  output lari_pkg::cmd_t       cmd
);
  import lari_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (req_valid) state_next = S_END_MUL;
      S_END_MUL:   state_next = S_END_SET;
      S_END_SET:   state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (stat.op)
          OP_TO_RADIUS: state_next = stat.ge_end ? S_DONE : S_K_DIV;
          OP_TO_ANGLE:  state_next = stat.gt_last ? S_DONE : S_SRCH_INIT;
          default:      state_next = S_DONE;
        endcase
      end
      S_K_DIV:     state_next = S_K_WAIT;
      S_K_WAIT:    if (stat.div_done) state_next = S_K_SET;
      S_K_SET:     state_next = S_K_MUL;
      S_K_MUL:     state_next = S_FRAC;
      S_FRAC:      state_next = S_MUL_B;
      S_MUL_B:     state_next = S_MUL_U;
      S_MUL_U:     state_next = S_ACC;
      S_ACC:       state_next = S_I_DIV;
      S_I_DIV:     state_next = S_I_WAIT;
      S_I_WAIT:    if (stat.div_done) state_next = S_I_RES;
      S_I_RES:     state_next = S_DONE;
      S_SRCH_INIT: state_next = S_SRCH;
      S_SRCH:      state_next = stat.more ? S_SRCH_CMP : S_PB;
      S_SRCH_CMP:  state_next = S_SRCH;
      S_PB:        state_next = S_PU;
      S_PU:        state_next = S_DEG;
      S_DEG:       state_next = stat.degen ? S_DONE : S_D_DIV;
      S_D_DIV:     state_next = S_D_WAIT;
      S_D_WAIT:    if (stat.div_done) state_next = S_D_RES;
      S_D_RES:     state_next = S_DONE;
      S_DONE:      if (stat.out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd = CMD_LATCH;
      end
      S_END_MUL: cmd = CMD_END_MUL;
      S_END_SET: cmd = CMD_END_SET;
      S_DECIDE: begin
        unique case (stat.op)
          OP_TO_RADIUS: cmd = stat.ge_end ? CMD_RES_LAST : CMD_NONE;
          OP_TO_ANGLE:  cmd = stat.gt_last ? CMD_RES_END : CMD_NONE;
          default:      cmd = CMD_RES_ZERO;
        endcase
      end
      S_K_DIV:     cmd = CMD_DIV_K;
      S_K_SET:     cmd = CMD_K_SET;
      S_K_MUL:     cmd = CMD_K_MUL;
      S_FRAC:      cmd = CMD_FRAC;
      S_MUL_B:     cmd = CMD_MUL_B;
      S_MUL_U:     cmd = CMD_MUL_U;
      S_ACC:       cmd = CMD_ACC;
      S_I_DIV:     cmd = CMD_DIV_I;
      S_I_RES:     cmd = CMD_RES_Q;
      S_SRCH_INIT: cmd = CMD_SRCH_INIT;
      S_SRCH:      cmd = stat.more ? CMD_SRCH_RD : CMD_BASE_RD;
      S_SRCH_CMP:  cmd = CMD_SRCH_CMP;
      S_PB:        cmd = CMD_PB;
      S_PU:        cmd = CMD_PU;
      S_DEG:       cmd = stat.degen ? CMD_RES_BASE : CMD_D_MUL;
      S_D_DIV:     cmd = CMD_DIV_D;
      S_D_RES:     cmd = CMD_RES_ADD;
      S_DONE:      if (stat.out_free) cmd = CMD_PUSH;
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule
